// ----- hw/rtl/cpd_pkg.sv -----
// Shared types, constants and helper functions for the command packet deframer.
`timescale 1ns / 1ps
package cpd_pkg;

  localparam logic [7:0] HEADER_BYTES = 8'd6;
  localparam logic [7:0] MIN_LENGTH   = 8'd7;
  localparam logic [2:0] POS_FLAGS    = 3'd4;
  localparam logic [2:0] POS_LENGTH   = 3'd5;

  localparam logic KIND_BODY    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_DRIVE  = 3'd1,
    CMD_STATUS = 3'd2,
    CMD_SLEEP  = 3'd3,
    CMD_ARM    = 3'd4,
    CMD_CLAW   = 3'd5
  } cmd_t;

  // One result word as it travels from the parser to the output register.
  typedef struct packed {
    logic        result_kind;
    logic [7:0]  body_byte;
    logic [31:0] packet_count;
    logic [2:0]  command;
    logic        ack_flag;
    logic [5:0]  flag_bits;
    logic [7:0]  total_length;
    logic        check_ok;
    logic        length_error;
    logic        last_of_packet;
  } result_t;

  function automatic logic [3:0] ones_in(input logic [7:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int k = 0; k < 8; k++) begin
      n = n + {3'd0, v[k]};
    end
    return n;
  endfunction

  // Drive wins over status, then sleep, arm and claw.
  function automatic cmd_t decode_command(input logic [5:0] f);
    cmd_t c;
    priority if (f[2]) c = CMD_DRIVE;
    else if (f[1]) c = CMD_STATUS;
    else if (f[0]) c = CMD_SLEEP;
    else if (f[4]) c = CMD_ARM;
    else if (f[3]) c = CMD_CLAW;
    else c = CMD_NONE;
    return c;
  endfunction

endpackage

// ----- hw/rtl/cpd_parse.sv -----
// Packet state tracking and per-word result generation for the deframer.
`timescale 1ns / 1ps
module cpd_parse
  import cpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       start_of_packet,
  output logic       res_valid,
  output result_t    res
);

  logic [7:0]  byte_pos_r, byte_pos_nxt;
  logic [7:0]  exp_len_r, exp_len_nxt;
  logic [7:0]  ones_sum_r, ones_sum_nxt;
  logic [31:0] count_r, count_nxt;
  logic [5:0]  flag_r, flag_nxt;
  logic        in_packet_r, in_packet_nxt;

  logic        active;
  logic [7:0]  pos_cur;
  logic [7:0]  len_cur;
  logic [7:0]  sum_cur;
  logic [31:0] cnt_cur;
  logic [5:0]  flg_cur;
  logic [7:0]  sum_add;
  logic [7:0]  end_pos;
  logic        short_len;
  logic        in_header;
  logic        at_end;

  // A start marker restarts the packet, so it overrides the stored state.
  always_comb begin
    active  = start_of_packet | in_packet_r;
    pos_cur = start_of_packet ? 8'd0 : byte_pos_r;
    len_cur = start_of_packet ? 8'd0 : exp_len_r;
    sum_cur = start_of_packet ? 8'd0 : ones_sum_r;
    cnt_cur = start_of_packet ? 32'd0 : count_r;
    flg_cur = start_of_packet ? 6'd0 : flag_r;
    sum_add   = sum_cur + {4'd0, ones_in(data_byte)};
    short_len = (len_cur < MIN_LENGTH);
    end_pos   = short_len ? HEADER_BYTES : (len_cur - 8'd1);
    in_header = (pos_cur < HEADER_BYTES);
    at_end    = !in_header && (pos_cur >= end_pos);
  end

  always_comb begin
    byte_pos_nxt  = byte_pos_r;
    exp_len_nxt   = exp_len_r;
    ones_sum_nxt  = ones_sum_r;
    count_nxt     = count_r;
    flag_nxt      = flag_r;
    in_packet_nxt = in_packet_r;
    if (accept && active) begin
      byte_pos_nxt  = pos_cur + 8'd1;
      exp_len_nxt   = len_cur;
      ones_sum_nxt  = sum_add;
      count_nxt     = cnt_cur;
      flag_nxt      = flg_cur;
      in_packet_nxt = 1'b1;
      if (in_header) begin
        if (pos_cur[2:0] == POS_FLAGS) begin
          flag_nxt = data_byte[5:0];
        end else if (pos_cur[2:0] == POS_LENGTH) begin
          exp_len_nxt = data_byte;
        end else begin
          count_nxt = cnt_cur | ({24'd0, data_byte} << {pos_cur[1:0], 3'd0});
        end
      end else if (at_end) begin
        byte_pos_nxt  = 8'd0;
        ones_sum_nxt  = sum_cur;
        in_packet_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    res       = '0;
    res_valid = active && !in_header;
    if (at_end) begin
      res.result_kind    = KIND_SUMMARY;
      res.packet_count   = cnt_cur;
      res.command        = decode_command(flg_cur);
      res.ack_flag       = flg_cur[5];
      res.flag_bits      = flg_cur;
      res.total_length   = len_cur;
      res.check_ok       = (data_byte == sum_cur);
      res.length_error   = short_len;
      res.last_of_packet = 1'b1;
    end else begin
      res.result_kind = KIND_BODY;
      res.body_byte   = data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r  <= 8'd0;
      exp_len_r   <= 8'd0;
      ones_sum_r  <= 8'd0;
      count_r     <= 32'd0;
      flag_r      <= 6'd0;
      in_packet_r <= 1'b0;
    end else begin
      byte_pos_r  <= byte_pos_nxt;
      exp_len_r   <= exp_len_nxt;
      ones_sum_r  <= ones_sum_nxt;
      count_r     <= count_nxt;
      flag_r      <= flag_nxt;
      in_packet_r <= in_packet_nxt;
    end
  end

`ifndef SYNTHESIS
  a_idle_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !in_packet_r |-> byte_pos_r == 8'd0)
    else $error("byte position nonzero while idle");

  a_summary_ends_packet: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && res_valid && res.last_of_packet) |=> !in_packet_r)
    else $error("packet still open after its summary word");

  a_no_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_packet_r && !start_of_packet) |-> !res_valid)
    else $error("result produced while idle");

  a_body_below_end: assert property (@(posedge clk) disable iff (!rst_n)
    (in_packet_r && byte_pos_r > HEADER_BYTES) |-> exp_len_r >= MIN_LENGTH)
    else $error("body word counted in a short packet");
`endif

endmodule

// ----- hw/rtl/cpd_outreg.sv -----
// Output register holding one result word until the receiver takes it.
`timescale 1ns / 1ps
module cpd_outreg
  import cpd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t load_data,
  output logic    can_load,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    valid_r, valid_nxt;
  result_t data_r;

  // The slot frees in the same cycle the receiver takes the held word.
  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ----- hw/rtl/command_packet_deframer_unit.sv -----
// Top level of the command packet deframer.
//
// Usage: one byte of the packet stream arrives per word on the in_ channel,
// with in_start_of_packet marking byte 0 of a packet. Bytes 0-3 carry the
// packet count, byte 4 the flags, byte 5 the length; header bytes give no
// result. Each body byte leaves as a body word on the out_ channel, and the
// check byte produces one summary word with the header fields, the decoded
// command, check_ok and length_error. Bytes outside a packet are dropped.
// An accepted word is loaded into the output register and shown on out_ in
// the next cycle. Throughput is one byte per cycle while out_ready is high,
// set by the single output register, which reloads in the same cycle its
// word is taken. When the receiver stalls, the held word stays put and
// in_ready drops until it is taken; no word is lost. Reset clears the packet
// state to idle and empties the output register.
`timescale 1ns / 1ps
module command_packet_deframer_unit
  import cpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_of_packet,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic [7:0]  out_body_byte,
  output logic [31:0] out_packet_count,
  output logic [2:0]  out_command,
  output logic        out_ack_flag,
  output logic [5:0]  out_flag_bits,
  output logic [7:0]  out_total_length,
  output logic        out_check_ok,
  output logic        out_length_error,
  output logic        out_last_of_packet
);

  logic    accept;
  logic    res_valid;
  result_t res;
  result_t held;

  assign accept = in_valid && in_ready;

  cpd_parse u_parse (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .data_byte       (in_data_byte),
    .start_of_packet (in_start_of_packet),
    .res_valid       (res_valid),
    .res             (res)
  );

  cpd_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept && res_valid),
    .load_data (res),
    .can_load  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (held)
  );

  assign out_result_kind    = held.result_kind;
  assign out_body_byte      = held.body_byte;
  assign out_packet_count   = held.packet_count;
  assign out_command        = held.command;
  assign out_ack_flag       = held.ack_flag;
  assign out_flag_bits      = held.flag_bits;
  assign out_total_length   = held.total_length;
  assign out_check_ok       = held.check_ok;
  assign out_length_error   = held.length_error;
  assign out_last_of_packet = held.last_of_packet;

endmodule

// ----- sim/command_packet_deframer_unit_tb.sv -----
// Self-checking testbench for the command packet deframer: directed and random byte streams.
`timescale 1ns / 1ps
module command_packet_deframer_unit_tb
  import cpd_pkg::*;
();

  localparam int IDLE_PCT    = 23;
  localparam int STREAM_BYTES = 1450;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 4;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_start_of_packet;
  logic        out_valid;
  logic        out_ready;
  logic        out_result_kind;
  logic [7:0]  out_body_byte;
  logic [31:0] out_packet_count;
  logic [2:0]  out_command;
  logic        out_ack_flag;
  logic [5:0]  out_flag_bits;
  logic [7:0]  out_total_length;
  logic        out_check_ok;
  logic        out_length_error;
  logic        out_last_of_packet;

  command_packet_deframer_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_start_of_packet (in_start_of_packet),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result_kind    (out_result_kind),
    .out_body_byte      (out_body_byte),
    .out_packet_count   (out_packet_count),
    .out_command        (out_command),
    .out_ack_flag       (out_ack_flag),
    .out_flag_bits      (out_flag_bits),
    .out_total_length   (out_total_length),
    .out_check_ok       (out_check_ok),
    .out_length_error   (out_length_error),
    .out_last_of_packet (out_last_of_packet)
  );

  // Deframer state as the testbench tracks it.
  logic        rx_active;
  logic [7:0]  rx_pos;
  logic [7:0]  rx_len;
  logic [7:0]  rx_ones;
  logic [31:0] rx_count;
  logic [5:0]  rx_flags;

  result_t     predicted_words[$];
  int          framed_bytes;
  int          mismatches;
  int          quiet_cycles;
  bit          steady;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic cmd_t command_of(input logic [5:0] f);
    casez (f[4:0])
      5'b??1??: return CMD_DRIVE;
      5'b???1?: return CMD_STATUS;
      5'b????1: return CMD_SLEEP;
      5'b1????: return CMD_ARM;
      5'b?1???: return CMD_CLAW;
      default:  return CMD_NONE;
    endcase
  endfunction

  // Updates the tracked state for one accepted byte and queues the word it causes, if any.
  task automatic deframe_byte(input logic [7:0] b, input logic sop);
    result_t    r;
    logic [7:0] check_pos;
    if (sop) begin
      rx_active = 1'b1;
      rx_pos    = '0;
      rx_len    = '0;
      rx_ones   = '0;
      rx_count  = '0;
      rx_flags  = '0;
    end
    if (!rx_active) return;
    framed_bytes++;
    if (rx_pos < HEADER_BYTES) begin
      if (rx_pos < 8'(POS_FLAGS)) rx_count[8 * rx_pos[1:0] +: 8] = b;
      else if (rx_pos == 8'(POS_FLAGS)) rx_flags = b[5:0];
      else rx_len = b;
      rx_ones = rx_ones + 8'($countones(b));
      rx_pos  = rx_pos + 8'd1;
      return;
    end
    r = '0;
    check_pos = (rx_len < MIN_LENGTH) ? HEADER_BYTES : rx_len - 8'd1;
    if (rx_pos >= check_pos) begin
      r.result_kind    = KIND_SUMMARY;
      r.packet_count   = rx_count;
      r.command        = command_of(rx_flags);
      r.ack_flag       = rx_flags[5];
      r.flag_bits      = rx_flags;
      r.total_length   = rx_len;
      r.check_ok       = (b == rx_ones);
      r.length_error   = (rx_len < MIN_LENGTH);
      r.last_of_packet = 1'b1;
      rx_active = 1'b0;
      rx_pos    = '0;
    end else begin
      rx_ones = rx_ones + 8'($countones(b));
      rx_pos  = rx_pos + 8'd1;
      r.result_kind = KIND_BODY;
      r.body_byte   = b;
    end
    predicted_words.push_back(r);
  endtask

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_byte(input logic [7:0] b, input logic sop);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_data_byte       <= b;
    in_start_of_packet <= sop;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    deframe_byte(b, sop);
    @(negedge clk);
  endtask

  // Sends a packet with a random body. A nonzero cut stops after that many bytes,
  // leaving the packet open for the next start of packet to drop.
  task automatic send_packet(input logic [31:0] count, input logic [7:0] flags,
                             input logic [7:0] len, input int cut, input bit bad_check);
    int         total;
    logic [7:0] b;
    logic [7:0] ones;
    total = (len < MIN_LENGTH) ? 7 : int'(len);
    ones  = '0;
    for (int idx = 0; idx < total; idx++) begin
      if (cut != 0 && idx == cut) return;
      if (idx < 4) b = count[8 * idx +: 8];
      else if (idx == 4) b = flags;
      else if (idx == 5) b = len;
      else if (idx == total - 1) begin
        b = ones;
        if (bad_check) b[$urandom_range(7)] = ~b[$urandom_range(7)];
      end else b = 8'($urandom_range(255));
      // A flipped bit at a random position could land back on the same value.
      if (idx == total - 1 && bad_check && b == ones) b = ~ones;
      ones = ones + 8'($countones(b));
      send_byte(b, idx == 0);
    end
  endtask

  task automatic random_traffic(input int n_bytes);
    int         goal;
    int         pick;
    logic [7:0] flags;
    logic [7:0] len;
    goal = framed_bytes + n_bytes;
    while (framed_bytes < goal) begin
      flags = 8'($urandom_range(255));
      case ($urandom_range(3))
        0: flags[4:0] = 5'(1 << $urandom_range(4));
        1: flags[4:0] = '0;
        default: ;
      endcase
      pick = $urandom_range(99);
      if (pick < 8) len = 8'($urandom_range(6));
      else if (pick < 10) len = ($urandom_range(3) == 0) ? 8'd255 : 8'($urandom_range(100, 254));
      else len = 8'($urandom_range(7, 20));
      pick = $urandom_range(99);
      if (pick < 85) begin
        send_packet($urandom(), flags, len, 0, $urandom_range(99) < 15);
      end else if (pick < 93) begin
        send_packet($urandom(), flags, len, $urandom_range(1, 6), 1'b0);
      end else begin
        // Noise: ignored while idle, taken as packet bytes after a cut packet.
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)), 1'b0);
      end
    end
  endtask

  task automatic test_idle_bytes();
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
  endtask

  task automatic test_short_length();
    send_packet(32'hFFFF_FFFF, 8'hFF, 8'd6, 0, 1'b0);
  endtask

  task automatic test_resync();
    send_packet(32'h1234_5678, 8'h04, 8'd9, 2, 1'b0);
    send_packet(32'h0000_0000, 8'hE0, 8'd8, 0, 1'b1);
  endtask

  task automatic test_back_to_back();
    steady = 1'b1;
    random_traffic(250);
    steady = 1'b0;
  endtask

  task automatic test_random_traffic();
    random_traffic(STREAM_BYTES - 250);
  endtask

  function automatic void match(input string field, input logic [31:0] want,
                                input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatches++;
    end
  endfunction

  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (predicted_words.size() == 0) begin
        $error("result word with none expected");
        mismatches++;
      end else begin
        want = predicted_words.pop_front();
        match("result_kind", 32'(want.result_kind), 32'(out_result_kind));
        match("body_byte", 32'(want.body_byte), 32'(out_body_byte));
        match("packet_count", want.packet_count, out_packet_count);
        match("command", 32'(want.command), 32'(out_command));
        match("ack_flag", 32'(want.ack_flag), 32'(out_ack_flag));
        match("flag_bits", 32'(want.flag_bits), 32'(out_flag_bits));
        match("total_length", 32'(want.total_length), 32'(out_total_length));
        match("check_ok", 32'(want.check_ok), 32'(out_check_ok));
        match("length_error", 32'(want.length_error), 32'(out_length_error));
        match("last_of_packet", 32'(want.last_of_packet), 32'(out_last_of_packet));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_data_byte       = '0;
    in_start_of_packet = 1'b0;
    out_ready          = 1'b0;
    steady             = 1'b0;
    rx_active          = 1'b0;
    rx_pos             = '0;
    rx_len             = '0;
    rx_ones            = '0;
    rx_count           = '0;
    rx_flags           = '0;
    framed_bytes       = 0;
    mismatches         = 0;
    quiet_cycles       = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_idle_bytes();
    test_short_length();
    test_resync();
    test_back_to_back();
    test_random_traffic();

    in_valid <= 1'b0;
    while (predicted_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/cpd_pkg.sv
hw/rtl/cpd_parse.sv
hw/rtl/cpd_outreg.sv
hw/rtl/command_packet_deframer_unit.sv
sim/command_packet_deframer_unit_tb.sv
